// ===== rtl/elpf_pkg.sv =====
// shared types and constants for the ethernet l4 port packet filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package elpf_pkg;

  localparam int DEFAULT_PORT_SLOTS = 32;
  localparam int GROUP_SLOTS        = 16;
  localparam int QUEUE_DEPTH        = 4;
  localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic CMD_TABLE_WRITE = 1'b0;
  localparam logic CMD_FRAME_BYTE  = 1'b1;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_IPV6   = 16'h86DD;
  localparam logic [15:0] ETH_TAG_Q  = 16'h8100;
  localparam logic [15:0] ETH_TAG_AD = 16'h88A8;
  localparam logic [15:0] FRAG_MASK  = 16'h1FFF;

  localparam logic [3:0] IHL_MIN   = 4'd5;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [4:0] L3_PLAIN  = 5'd14;
  localparam logic [4:0] L3_TAGGED = 5'd18;
  localparam logic [6:0] POS_MAX   = 7'd127;

  typedef enum logic [2:0] {
    VERDICT_KEPT     = 3'd0,
    VERDICT_TRUNC    = 3'd1,
    VERDICT_NOT_IP   = 3'd2,
    VERDICT_BAD_IHL  = 3'd3,
    VERDICT_FRAG     = 3'd4,
    VERDICT_NOT_L4   = 3'd5,
    VERDICT_NO_MATCH = 3'd6
  } verdict_t;

  // one queued job: a table write or a frame waiting for its port match
  typedef struct packed {
    logic             is_write;
    logic [4:0]       slot_index;
    logic [15:0]      slot_port;
    logic             slot_enable;
    verdict_t         code;
    logic             need_match;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/elpf_front.sv =====
// byte parser: tracks header offsets, captures l4 ports, forms the pre-match verdict
// depends on elpf_pkg; feeds elpf_fifo
`timescale 1ns / 1ps

module elpf_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [7:0]              in_frame_byte,
  input  logic                    in_frame_end,
  input  logic [4:0]              in_slot_index,
  input  logic [15:0]             in_slot_port,
  input  logic                    in_slot_enable,
  output logic                    push,
  output elpf_pkg::queue_entry_t  push_entry,
  input  elpf_pkg::queue_status_t q_status
);
  import elpf_pkg::*;

  logic        accept;
  logic        byte_take;
  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] ek_r, ek_mid, ek_nxt;
  logic [4:0]  l3_r, l3_nxt;
  logic [6:0]  l4_r, l4_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  tk_r, tk_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] dst_r, dst_nxt;
  logic [6:0]  l3_ext, rel3, rel4;
  logic        in_l3;
  logic [7:0]  len, l3_len, l4_need;
  verdict_t    code;
  logic        need_match;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign byte_take = accept && (in_command == CMD_FRAME_BYTE);

  always_comb begin
    ek_mid = ek_r;
    if (pos_r == 7'd12 || pos_r == 7'd13) begin
      ek_mid = {ek_r[7:0], in_frame_byte};
    end
    l3_nxt = l3_r;
    if (pos_r == 7'd13 && (ek_mid == ETH_TAG_Q || ek_mid == ETH_TAG_AD)) begin
      l3_nxt = L3_TAGGED;
    end
    ek_nxt = ek_mid;
    if (l3_nxt == L3_TAGGED && (pos_r == 7'd16 || pos_r == 7'd17)) begin
      ek_nxt = {ek_mid[7:0], in_frame_byte};
    end

    l3_ext   = {2'b00, l3_nxt};
    in_l3    = (pos_r >= l3_ext);
    rel3     = pos_r - l3_ext;
    hw_nxt   = hw_r;
    l4_nxt   = l4_r;
    frag_nxt = frag_r;
    tk_nxt   = tk_r;
    if (ek_nxt == ETH_IPV4 && in_l3) begin
      if (rel3 == 7'd0) begin
        hw_nxt = in_frame_byte[3:0];
        l4_nxt = l3_ext + {1'b0, in_frame_byte[3:0], 2'b00};
      end else if (rel3 == 7'd6 || rel3 == 7'd7) begin
        frag_nxt = {frag_r[7:0], in_frame_byte};
      end else if (rel3 == 7'd9) begin
        tk_nxt = in_frame_byte;
      end
    end else if (ek_nxt == ETH_IPV6 && in_l3) begin
      if (rel3 == 7'd0) begin
        l4_nxt = l3_ext + 7'd40;
      end else if (rel3 == 7'd6) begin
        tk_nxt = in_frame_byte;
      end
    end

    // port bytes: source in the first two, destination in the next two
    rel4    = pos_r - l4_nxt;
    src_nxt = src_r;
    dst_nxt = dst_r;
    if (l4_nxt != 7'd0 && pos_r >= l4_nxt && rel4 < 7'd4) begin
      if (rel4 < 7'd2) begin
        src_nxt = {src_r[7:0], in_frame_byte};
      end else begin
        dst_nxt = {dst_r[7:0], in_frame_byte};
      end
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 7'd1;
  end

  // verdict on the last byte, before the table match
  always_comb begin
    len     = {1'b0, pos_r} + 8'd1;
    l3_len  = {3'b000, l3_nxt};
    l4_need = {1'b0, l4_nxt} + ((tk_nxt == PROTO_UDP) ? 8'd8 : 8'd20);
    need_match = 1'b0;
    priority if (len < 8'd14) begin
      code = VERDICT_TRUNC;
    end else if (len < l3_len) begin
      code = VERDICT_TRUNC;
    end else if (ek_nxt == ETH_IPV4 && len < l3_len + 8'd20) begin
      code = VERDICT_TRUNC;
    end else if (ek_nxt == ETH_IPV4 && hw_nxt < IHL_MIN) begin
      code = VERDICT_BAD_IHL;
    end else if (ek_nxt == ETH_IPV4 && (frag_nxt & FRAG_MASK) != 16'd0) begin
      code = VERDICT_FRAG;
    end else if (ek_nxt == ETH_IPV6 && len < l3_len + 8'd40) begin
      code = VERDICT_TRUNC;
    end else if (ek_nxt != ETH_IPV4 && ek_nxt != ETH_IPV6) begin
      code = VERDICT_NOT_IP;
    end else if (tk_nxt != PROTO_UDP && tk_nxt != PROTO_TCP) begin
      code = VERDICT_NOT_L4;
    end else if (len < l4_need) begin
      code = VERDICT_TRUNC;
    end else begin
      code       = VERDICT_NO_MATCH;
      need_match = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ek_r   <= '0;
      l3_r   <= L3_PLAIN;
      l4_r   <= '0;
      hw_r   <= '0;
      frag_r <= '0;
      tk_r   <= '0;
      src_r  <= '0;
      dst_r  <= '0;
    end else if (byte_take) begin
      if (in_frame_end) begin
        pos_r  <= '0;
        ek_r   <= '0;
        l3_r   <= L3_PLAIN;
        l4_r   <= '0;
        hw_r   <= '0;
        frag_r <= '0;
        tk_r   <= '0;
        src_r  <= '0;
        dst_r  <= '0;
      end else begin
        pos_r  <= pos_nxt;
        ek_r   <= ek_nxt;
        l3_r   <= l3_nxt;
        l4_r   <= l4_nxt;
        hw_r   <= hw_nxt;
        frag_r <= frag_nxt;
        tk_r   <= tk_nxt;
        src_r  <= src_nxt;
        dst_r  <= dst_nxt;
      end
    end
  end

  assign push = accept && (in_command == CMD_TABLE_WRITE || in_frame_end);

  always_comb begin
    push_entry.is_write    = (in_command == CMD_TABLE_WRITE);
    push_entry.slot_index  = in_slot_index;
    push_entry.slot_port   = in_slot_port;
    push_entry.slot_enable = in_slot_enable;
    push_entry.code        = code;
    push_entry.need_match  = need_match;
    push_entry.src_port    = src_nxt;
    push_entry.dst_port    = dst_nxt;
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    byte_take && in_frame_end |=> pos_r == 7'd0 && l3_r == L3_PLAIN && l4_r == 7'd0)
    else $error("parse state not cleared after last byte");

endmodule

// ===== rtl/elpf_fifo.sv =====
// short job queue between the parser and the match stage
// depends on elpf_pkg
`timescale 1ns / 1ps

module elpf_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  elpf_pkg::queue_entry_t  push_entry,
  input  logic                    pop,
  output elpf_pkg::queue_entry_t  head,
  output elpf_pkg::queue_status_t status
);
  import elpf_pkg::*;

  queue_entry_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   cnt_r;

  assign status.full  = (cnt_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/elpf_back.sv =====
// port table, grouped parallel match and the result register
// depends on elpf_pkg; drains elpf_fifo
`timescale 1ns / 1ps

module elpf_back #(
  parameter int PORT_SLOTS = elpf_pkg::DEFAULT_PORT_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  elpf_pkg::queue_entry_t  head,
  input  elpf_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_keep_frame,
  output logic [2:0]              out_verdict_code
);
  import elpf_pkg::*;

  localparam int GROUPS = (PORT_SLOTS + GROUP_SLOTS - 1) / GROUP_SLOTS;

  logic [15:0]           port_r [PORT_SLOTS];
  logic [PORT_SLOTS-1:0] en_r;
  logic [GROUPS-1:0]     grp_hit;
  logic                  adv;
  logic                  tbl_write;

  logic                  b_valid_r;
  verdict_t              b_code_r;
  logic                  b_need_r;
  logic [GROUPS-1:0]     b_hit_r;

  logic                  out_valid_r;
  logic                  out_keep_r;
  verdict_t              out_code_r;
  verdict_t              final_code;

  // whole back pipe moves when the result register is free or being taken
  assign adv       = !out_valid_r || !out_stall;
  assign pop       = adv && !q_status.empty;
  assign tbl_write = pop && head.is_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else if (tbl_write) begin
      for (int i = 0; i < PORT_SLOTS; i++) begin
        if (int'(head.slot_index) == i) begin
          en_r[i] <= head.slot_enable;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_write && head.slot_enable) begin
      for (int i = 0; i < PORT_SLOTS; i++) begin
        if (int'(head.slot_index) == i) begin
          port_r[i] <= head.slot_port;
        end
      end
    end
  end

  // per group hit flags, or-ed together in the next stage
  always_comb begin
    int s;
    grp_hit = '0;
    for (int g = 0; g < GROUPS; g++) begin
      for (int k = 0; k < GROUP_SLOTS; k++) begin
        s = g * GROUP_SLOTS + k;
        if (s < PORT_SLOTS) begin
          if (en_r[s] && (port_r[s] == head.src_port || port_r[s] == head.dst_port)) begin
            grp_hit[g] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= pop && !head.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_code_r <= head.code;
      b_need_r <= head.need_match;
      b_hit_r  <= grp_hit;
    end
  end

  always_comb begin
    final_code = b_code_r;
    if (b_need_r) begin
      final_code = (|b_hit_r) ? VERDICT_KEPT : VERDICT_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_code_r <= final_code;
      out_keep_r <= (final_code == VERDICT_KEPT);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_keep_frame   = out_keep_r;
  assign out_verdict_code = out_code_r;

  a_keep_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_keep_r == (out_code_r == VERDICT_KEPT))
    else $error("keep flag disagrees with verdict");

  a_write_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_write |=> !b_valid_r)
    else $error("table write produced a result");

endmodule

// ===== rtl/ethernet_l4_port_packet_filter.sv =====
// top level of the ethernet l4 port packet filter
// depends on elpf_pkg, elpf_front, elpf_fifo, elpf_back
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_stall): one transaction per cycle while in_stall
//   is low, either a frame byte (in_command = frame byte, in_frame_end marks the
//   last byte) or a port table write (in_slot_index, in_slot_port, in_slot_enable)
//   result channel (out_valid / out_stall): one transaction per frame, after its
//   last byte: out_keep_frame and out_verdict_code
// throughput: one input transaction every cycle while the queue is not full, set by
//   the byte parser, which handles each byte combinationally, and by the match stage,
//   which compares both ports against the whole table in one pass
// after its last byte is accepted, a result passes through the queue, the match
//   stage register and the result register
// reset: synchronous, active low; clears the parse state, the queue and all
//   table enables, so every slot starts disabled; no clearing pass is needed
// receiver stall: the result register holds, the match stage halts and the
//   queue fills; in_stall rises only once the queue is full, so bytes that
//   end no frame keep flowing until then
// table writes travel through the same queue as frame verdicts, so a frame
//   is matched against the table as it stands when its last byte arrives
module ethernet_l4_port_packet_filter #(
  parameter int PORT_SLOTS = elpf_pkg::DEFAULT_PORT_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  input  logic [4:0]  in_slot_index,
  input  logic [15:0] in_slot_port,
  input  logic        in_slot_enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_keep_frame,
  output logic [2:0]  out_verdict_code
);
  import elpf_pkg::*;

  // parser to queue
  logic          push;
  queue_entry_t  push_entry;
  // queue to match stage
  logic          pop;
  queue_entry_t  head;
  queue_status_t q_status;

  elpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_frame_byte  (in_frame_byte),
    .in_frame_end   (in_frame_end),
    .in_slot_index  (in_slot_index),
    .in_slot_port   (in_slot_port),
    .in_slot_enable (in_slot_enable),
    .push           (push),
    .push_entry     (push_entry),
    .q_status       (q_status)
  );

  elpf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // match stage: table lives here so writes stay in order with verdicts
  elpf_back #(
    .PORT_SLOTS (PORT_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_status         (q_status),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_keep_frame   (out_keep_frame),
    .out_verdict_code (out_verdict_code)
  );

endmodule

// ===== tb/sv/ethernet_l4_port_packet_filter_tb.sv =====
// self-checking testbench for the ethernet l4 port packet filter
// random frames and port table writes, checked against a behavioral parser
// depends on elpf_pkg and the ethernet_l4_port_packet_filter rtl
`timescale 1ns / 1ps

module ethernet_l4_port_packet_filter_tb;
  import elpf_pkg::*;

  localparam int PORT_SLOTS   = DEFAULT_PORT_SLOTS;
  localparam int RANDOM_ITEMS = 1450;
  localparam int MIN_FRAMES   = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 8;

  // header geometry used by the parser
  localparam int ETYPE_AT       = 12;
  localparam int INNER_ETYPE_AT = 16;
  localparam int IPV4_HDR       = 20;
  localparam int IPV6_HDR       = 40;
  localparam int UDP_HDR        = 8;
  localparam int TCP_HDR        = 20;

  // one input transaction plus its pacing
  typedef struct {
    logic        cmd;
    logic [7:0]  data;
    logic        last;
    logic [4:0]  slot;
    logic [15:0] port;
    logic        en;
    int unsigned gap;
    bit          drain;
  } filter_txn_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_command     = CMD_TABLE_WRITE;
  logic [7:0]  in_frame_byte  = '0;
  logic        in_frame_end   = 1'b0;
  logic [4:0]  in_slot_index  = '0;
  logic [15:0] in_slot_port   = '0;
  logic        in_slot_enable = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_keep_frame;
  logic [2:0]  out_verdict_code;

  filter_txn_t pending_txns[$];
  verdict_t    expected_verdicts[$];
  int          fail_count  = 0;
  int          cycle_count = 0;

  // parser state, mirrors the block after reset
  logic [6:0]  pos_cnt;
  logic [15:0] eth_type;
  logic [4:0]  ip_base;
  logic [6:0]  l4_base;
  logic [3:0]  ihl_words;
  logic [15:0] frag_word;
  logic [7:0]  l4_proto;
  logic [15:0] src_port_q;
  logic [15:0] dst_port_q;
  logic [16:0] port_tab [PORT_SLOTS];

  // generator side copy of the table, only steers port choice
  logic        gen_en   [PORT_SLOTS];
  logic [15:0] gen_port [PORT_SLOTS];
  bit          calm_source = 1'b0;
  bit          calm_sink   = 1'b0;

  ethernet_l4_port_packet_filter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_frame_byte    (in_frame_byte),
    .in_frame_end     (in_frame_end),
    .in_slot_index    (in_slot_index),
    .in_slot_port     (in_slot_port),
    .in_slot_enable   (in_slot_enable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_keep_frame   (out_keep_frame),
    .out_verdict_code (out_verdict_code)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  // back to the start-of-frame state
  task automatic clear_parse();
    pos_cnt    = '0;
    eth_type   = '0;
    ip_base    = L3_PLAIN;
    l4_base    = '0;
    ihl_words  = '0;
    frag_word  = '0;
    l4_proto   = '0;
    src_port_q = '0;
    dst_port_q = '0;
  endtask

  function automatic bit port_listed(logic [15:0] port);
    for (int i = 0; i < PORT_SLOTS; i++) begin
      if (port_tab[i][16] && port_tab[i][15:0] == port) return 1'b1;
    end
    return 1'b0;
  endfunction

  // fold one frame byte at position p into the header fields
  task automatic parse_byte(int unsigned p, logic [7:0] b);
    int unsigned r;
    if (p == ETYPE_AT || p == ETYPE_AT + 1) eth_type = {eth_type[7:0], b};
    // a single vlan tag moves the ip header by four bytes
    if (p == ETYPE_AT + 1 && (eth_type == ETH_TAG_Q || eth_type == ETH_TAG_AD))
      ip_base = L3_TAGGED;
    if (ip_base == L3_TAGGED && (p == INNER_ETYPE_AT || p == INNER_ETYPE_AT + 1))
      eth_type = {eth_type[7:0], b};

    if (eth_type == ETH_IPV4 && p >= ip_base) begin
      r = p - ip_base;
      if (r == 0) begin
        ihl_words = b[3:0];
        l4_base   = 7'(ip_base + 4 * b[3:0]);
      end else if (r == 6 || r == 7) begin
        frag_word = {frag_word[7:0], b};
      end else if (r == 9) begin
        l4_proto = b;
      end
    end else if (eth_type == ETH_IPV6 && p >= ip_base) begin
      r = p - ip_base;
      if (r == 0) l4_base = 7'(ip_base + IPV6_HDR);
      else if (r == 6) l4_proto = b;
    end

    // ports are the first four transport bytes
    if (l4_base != 0 && p >= l4_base && p < l4_base + 4) begin
      if (p - l4_base < 2) src_port_q = {src_port_q[7:0], b};
      else dst_port_q = {dst_port_q[7:0], b};
    end
  endtask

  // decision at the last byte, len is the frame length in bytes
  function automatic verdict_t frame_verdict(int unsigned len);
    int unsigned need;
    if (len < L3_PLAIN) return VERDICT_TRUNC;
    if (len < ip_base) return VERDICT_TRUNC;
    if (eth_type == ETH_IPV4) begin
      if (len < ip_base + IPV4_HDR) return VERDICT_TRUNC;
      if (ihl_words < IHL_MIN) return VERDICT_BAD_IHL;
      if ((frag_word & FRAG_MASK) != 0) return VERDICT_FRAG;
    end else if (eth_type == ETH_IPV6) begin
      if (len < ip_base + IPV6_HDR) return VERDICT_TRUNC;
    end else begin
      return VERDICT_NOT_IP;
    end
    if (l4_proto == PROTO_UDP) need = UDP_HDR;
    else if (l4_proto == PROTO_TCP) need = TCP_HDR;
    else return VERDICT_NOT_L4;
    if (len < l4_base + need) return VERDICT_TRUNC;
    if (port_listed(src_port_q) || port_listed(dst_port_q)) return VERDICT_KEPT;
    return VERDICT_NO_MATCH;
  endfunction

  // apply one accepted transaction, queue a verdict on a frame's last byte
  task automatic absorb_txn(filter_txn_t t);
    int unsigned p;
    if (t.cmd == CMD_TABLE_WRITE) begin
      port_tab[t.slot] = t.en ? {1'b1, t.port} : 17'd0;
    end else begin
      p = pos_cnt;
      parse_byte(p, t.data);
      if (pos_cnt != POS_MAX) pos_cnt = pos_cnt + 1'b1;
      if (t.last) begin
        expected_verdicts.push_back(frame_verdict(p + 1));
        clear_parse();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // every field random, so unused fields toggle too
  function automatic filter_txn_t noise_txn();
    filter_txn_t t;
    t.cmd   = 1'($urandom);
    t.data  = 8'($urandom);
    t.last  = 1'($urandom);
    t.slot  = 5'($urandom);
    t.port  = 16'($urandom);
    t.en    = 1'($urandom);
    t.gap   = calm_source ? 0 : $urandom_range(0, 3);
    t.drain = 1'b0;
    return t;
  endfunction

  task automatic queue_table_write(logic [4:0] slot, logic [15:0] port, logic en);
    filter_txn_t t;
    t      = noise_txn();
    t.cmd  = CMD_TABLE_WRITE;
    t.slot = slot;
    t.port = port;
    t.en   = en;
    pending_txns.push_back(t);
    gen_en[slot]   = en;
    gen_port[slot] = port;
  endtask

  task automatic queue_random_write();
    logic [15:0] port;
    port = ($urandom_range(0, 2) == 0) ? gen_port[$urandom_range(0, PORT_SLOTS - 1)]
                                       : 16'($urandom);
    queue_table_write(5'($urandom), port, $urandom_range(0, 9) < 6);
  endtask

  task automatic queue_byte(logic [7:0] data, logic last, bit drain);
    filter_txn_t t;
    t       = noise_txn();
    t.cmd   = CMD_FRAME_BYTE;
    t.data  = data;
    t.last  = last;
    t.drain = drain;
    pending_txns.push_back(t);
  endtask

  // half the picks try a table port (random if that slot is off), the rest the extremes or anything
  function automatic logic [15:0] pick_port();
    int unsigned s;
    s = $urandom_range(0, PORT_SLOTS - 1);
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return gen_en[s] ? gen_port[s] : 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return PROTO_UDP;
      4, 5, 6, 7: return PROTO_TCP;
      default:    return 8'($urandom);
    endcase
  endfunction

  // one frame: optional tags, ipv4 or ipv6 or other, ports, then maybe cut
  task automatic queue_frame(bit hold_first);
    logic [7:0]  fb[$];
    logic [15:0] etype;
    logic [15:0] frag;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
    int unsigned pick;
    int unsigned ihl;
    int unsigned cut;
    int unsigned wr_at;
    int unsigned pad;

    repeat (2 * 6) fb.push_back(8'($urandom));
    pick = $urandom_range(0, 11);
    if (pick >= 8) begin
      etype = pick[0] ? ETH_TAG_AD : ETH_TAG_Q;
      fb.push_back(etype[15:8]);
      fb.push_back(etype[7:0]);
      repeat (2) fb.push_back(8'($urandom));
      // stacked tags: only the outer one is removed
      if (pick == 11) begin
        fb.push_back(ETH_TAG_Q[15:8]);
        fb.push_back(ETH_TAG_Q[7:0]);
        repeat (2) fb.push_back(8'($urandom));
      end
    end

    pick = $urandom_range(0, 19);
    if (pick < 9) etype = ETH_IPV4;
    else if (pick < 16) etype = ETH_IPV6;
    else if (pick < 18) etype = 16'($urandom);
    else etype = ETH_IPV4 ^ (16'h0001 << $urandom_range(0, 15));
    fb.push_back(etype[15:8]);
    fb.push_back(etype[7:0]);

    proto = pick_proto();
    if (etype == ETH_IPV4) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) ihl = IHL_MIN;
      else if (pick < 8) ihl = $urandom_range(6, 15);
      else ihl = $urandom_range(0, 4);
      // version nibble is not checked, so vary it now and then
      fb.push_back({($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)});
      repeat (5) fb.push_back(8'($urandom));
      frag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {3'($urandom), 13'd0};
      fb.push_back(frag[15:8]);
      fb.push_back(frag[7:0]);
      fb.push_back(8'($urandom));
      fb.push_back(proto);
      repeat (10) fb.push_back(8'($urandom));
      if (ihl > IHL_MIN) repeat ((ihl - IHL_MIN) * 4) fb.push_back(8'($urandom));
    end else if (etype == ETH_IPV6) begin
      fb.push_back({4'd6, 4'($urandom)});
      repeat (5) fb.push_back(8'($urandom));
      fb.push_back(proto);
      repeat (IPV6_HDR - 7) fb.push_back(8'($urandom));
    end

    sp = pick_port();
    dp = pick_port();
    fb.push_back(sp[15:8]);
    fb.push_back(sp[7:0]);
    fb.push_back(dp[15:8]);
    fb.push_back(dp[7:0]);
    if (proto == PROTO_UDP) repeat (UDP_HDR - 4) fb.push_back(8'($urandom));
    else if (proto == PROTO_TCP) repeat (TCP_HDR - 4) fb.push_back(8'($urandom));
    else repeat ($urandom_range(0, 8)) fb.push_back(8'($urandom));

    pick = $urandom_range(0, 13);
    if (pick == 0) begin
      // long frame past the position counter's saturation
      pad = $urandom_range(128, 140);
      while (fb.size() < pad) fb.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom));
    end
    if (pick >= 10) begin
      cut = $urandom_range(1, fb.size() - 1);
      while (fb.size() > cut) void'(fb.pop_back());
    end

    // now and then a table write lands in the middle of the frame
    wr_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, fb.size() - 1) : fb.size();
    foreach (fb[i]) begin
      if (i == wr_at) queue_random_write();
      queue_byte(fb[i], i == fb.size() - 1, hold_first && i == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one transaction staged at a time, gap counted before it
  // ---------------------------------------------------------------------------
  filter_txn_t drive_txn;
  filter_txn_t staged_txn;
  bit          staged   = 1'b0;
  int unsigned wait_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      staged = 1'b0;
    end else if (!in_valid || !in_stall) begin
      // a transaction went through at this edge
      if (in_valid) absorb_txn(drive_txn);
      // a drain-marked transaction waits until every verdict is back
      if (!staged && pending_txns.size() != 0 &&
          !(pending_txns[0].drain && expected_verdicts.size() != 0)) begin
        staged_txn = pending_txns.pop_front();
        staged     = 1'b1;
        wait_cnt   = staged_txn.gap;
      end
      if (staged && wait_cnt == 0) begin
        drive_txn = staged_txn;
        staged    = 1'b0;
        in_valid       <= 1'b1;
        in_command     <= drive_txn.cmd;
        in_frame_byte  <= drive_txn.data;
        in_frame_end   <= drive_txn.last;
        in_slot_index  <= drive_txn.slot;
        in_slot_port   <= drive_txn.port;
        in_slot_enable <= drive_txn.en;
      end else begin
        in_valid <= 1'b0;
        if (staged) wait_cnt--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each verdict, stalls a random count after each one
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    verdict_t want;
    logic     want_keep;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected verdict: keep_frame %0d verdict_code %0d",
                 out_keep_frame, out_verdict_code);
          fail_count++;
        end else begin
          want      = expected_verdicts.pop_front();
          want_keep = (want == VERDICT_KEPT);
          if (out_keep_frame !== want_keep) begin
            $error("keep_frame: expected %0d, actual %0d", want_keep, out_keep_frame);
            fail_count++;
          end
          if (out_verdict_code !== want) begin
            $error("verdict_code: expected %0d, actual %0d", want, out_verdict_code);
            fail_count++;
          end
        end
        // switch between stalling and free-running stretches
        if ($urandom_range(0, 29) == 0) calm_sink = !calm_sink;
        stall_left = calm_sink ? 0 : $urandom_range(0, 3);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned base;
    int unsigned frames;
    int unsigned writes;
    int unsigned settle;
    bit          done;

    clear_parse();
    for (int i = 0; i < PORT_SLOTS; i++) begin
      port_tab[i] = '0;
      gen_en[i]   = 1'b0;
      gen_port[i] = '0;
    end

    // directed: table extremes, duplicate ports, a cleared slot
    queue_table_write(5'd0, 16'h0000, 1'b1);
    queue_table_write(5'd31, 16'hFFFF, 1'b1);
    queue_table_write(5'd5, 16'd80, 1'b1);
    queue_table_write(5'd6, 16'd80, 1'b1);
    queue_table_write(5'd7, 16'd53, 1'b1);
    queue_table_write(5'd7, 16'd53, 1'b0);
    queue_table_write(5'd10, 16'd443, 1'b1);
    queue_table_write(5'd12, 16'd4789, 1'b1);
    // single byte frame and a frame one short of the ethernet header
    queue_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < L3_PLAIN - 1; i++)
      queue_byte(i[0] ? 8'hFF : 8'h00, i == L3_PLAIN - 2, 1'b0);

    // random frames, table writes in between
    base   = pending_txns.size();
    frames = 0;
    while (pending_txns.size() - base < RANDOM_ITEMS || frames < MIN_FRAMES) begin
      if ($urandom_range(0, 4) == 0) calm_source = !calm_source;
      writes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (writes) queue_random_write();
      queue_frame(frames == 0 || $urandom_range(0, 19) == 0);
      frames++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the last verdict, then for the bench to stay quiet through the settle count
    settle = 0;
    done   = 1'b0;
    while (!done && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      if (pending_txns.size() == 0 && !staged && !in_valid && expected_verdicts.size() == 0)
        settle++;
      else
        settle = 0;
      done = (settle >= SETTLE);
    end

    if (done && fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
